FILE: rtl/atomic_scratchpad_bank_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the atomic scratchpad bank
// Implication checks on the block's internal control, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ATOMIC_SCRATCHPAD_BANK_TOP_ASSERT_SVH
`define ATOMIC_SCRATCHPAD_BANK_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASB_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASB_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASB_ASSERT_IMPL(name, clk, rst, ante, cons, msg)
`define ASB_ASSERT_NEXT(name, clk, rst, ante, cons, msg)

`endif

`endif

FILE: rtl/asb_pkg.sv
// ----------------------------------------------------------------------------
// asb_pkg
// Types, codes and lane helpers shared by the atomic scratchpad bank.
// ----------------------------------------------------------------------------
package asb_pkg;

   localparam int ADDR_W      = 10;
   localparam int IDX_MAX_W   = 16;
   localparam int DATA_W      = 64;
   localparam int BYTE_LANES  = 8;
   localparam int QUEUE_DEPTH = 2;

   // request operation codes (the unused code acts as a read)
   localparam logic [2:0] REQ_READ  = 3'd0;
   localparam logic [2:0] REQ_ADD   = 3'd1;
   localparam logic [2:0] REQ_SUB   = 3'd2;
   localparam logic [2:0] REQ_MUL   = 3'd3;
   localparam logic [2:0] REQ_MAX   = 3'd4;
   localparam logic [2:0] REQ_MIN   = 3'd5;
   localparam logic [2:0] REQ_WRITE = 3'd6;

   // element size codes
   localparam logic [1:0] ESZ_1 = 2'd0;
   localparam logic [1:0] ESZ_2 = 2'd1;
   localparam logic [1:0] ESZ_4 = 2'd2;
   localparam logic [1:0] ESZ_8 = 2'd3;

   typedef enum logic [2:0] {
      EX_READ,
      EX_ADD,
      EX_SUB,
      EX_MUL,
      EX_MAX,
      EX_MIN,
      EX_WRITE
   } exec_op_type;

   typedef enum logic [2:0] {
      BS_IDLE,
      BS_LOAD,
      BS_EXEC,
      BS_MUL,
      BS_WRITE
   } back_state_type;

   // classified word handed from front to back
   typedef struct packed {
      exec_op_type           op;
      logic [IDX_MAX_W-1:0]  idx;
      logic [1:0]            elem_size;
      logic [DATA_W-1:0]     operand;
      logic [BYTE_LANES-1:0] write_mask;
      logic                  mask_error;
   } asb_item_type;

   // bit i set when byte i opens an element
   function automatic logic [BYTE_LANES-1:0] lane_starts(input logic [1:0] esz);
      logic [BYTE_LANES-1:0] s;
      s = '0;
      case (esz)
         ESZ_1:   s = 8'hFF;
         ESZ_2:   s = 8'h55;
         ESZ_4:   s = 8'h11;
         default: s = 8'h01;
      endcase
      return s;
   endfunction

   // bytes that exist in a line of lb bytes
   function automatic logic [BYTE_LANES-1:0] line_byte_mask(input int lb);
      logic [BYTE_LANES-1:0] m;
      m = '0;
      for (int i = 0; i < BYTE_LANES; i++) m[i] = (i < lb);
      return m;
   endfunction

   function automatic logic [DATA_W-1:0] line_bit_mask(input int lb);
      logic [DATA_W-1:0] m;
      m = '0;
      for (int i = 0; i < BYTE_LANES; i++) m[8*i +: 8] = {8{(i < lb)}};
      return m;
   endfunction

   // byte-wise adder whose carry restarts with cin at every element start
   function automatic logic [DATA_W-1:0] seg_add(input logic [DATA_W-1:0]     a,
                                                 input logic [DATA_W-1:0]     b,
                                                 input logic                  cin,
                                                 input logic [BYTE_LANES-1:0] starts);
      logic [DATA_W-1:0] sum;
      logic              carry;
      logic [8:0]        part;
      sum   = '0;
      carry = 1'b0;
      for (int i = 0; i < BYTE_LANES; i++) begin
         if (starts[i]) carry = cin;
         part = {1'b0, a[8*i +: 8]} + {1'b0, b[8*i +: 8]} + {8'd0, carry};
         sum[8*i +: 8] = part[7:0];
         carry = part[8];
      end
      return sum;
   endfunction

endpackage

FILE: rtl/asb_front.sv
// ----------------------------------------------------------------------------
// asb_front
// Classifies an incoming word: decodes the operation, folds the line address
// into the bank, checks the byte mask against element boundaries.
// ----------------------------------------------------------------------------
module asb_front #(
   parameter int LINE_BYTES = 8,
   parameter int BANK_LINES = 1024
) (
   input  logic [2:0]                     req_type,
   input  logic [asb_pkg::ADDR_W-1:0]     line_addr,
   input  logic [1:0]                     elem_size,
   input  logic [asb_pkg::DATA_W-1:0]     operand,
   input  logic [asb_pkg::BYTE_LANES-1:0] byte_mask,
   output asb_pkg::asb_item_type          item
);
   import asb_pkg::*;

   localparam logic [BYTE_LANES-1:0] LINE_BYTE_MASK = line_byte_mask(LINE_BYTES);
   localparam logic [DATA_W-1:0]     LINE_BIT_MASK  = line_bit_mask(LINE_BYTES);

   exec_op_type           op;
   logic [ADDR_W-1:0]     rem;
   logic [BYTE_LANES-1:0] starts;
   logic                  split;

   // operation decode
   always_comb begin
      unique case (req_type)
         REQ_READ:  op = EX_READ;
         REQ_ADD:   op = EX_ADD;
         REQ_SUB:   op = EX_SUB;
         REQ_MUL:   op = EX_MUL;
         REQ_MAX:   op = EX_MAX;
         REQ_MIN:   op = EX_MIN;
         REQ_WRITE: op = EX_WRITE;
         default:   op = EX_READ;
      endcase
   end

   // address modulo bank size, restoring remainder against shifted bank size
   always_comb begin
      rem = line_addr;
      for (int k = ADDR_W - 1; k >= 0; k--) begin
         if ({17'd0, rem} >= (27'(BANK_LINES) << k))
            rem = rem - ADDR_W'(27'(BANK_LINES) << k);
      end
   end

   // mask must agree with its neighbor inside an element, within the line
   always_comb begin
      starts = lane_starts(elem_size);
      split  = 1'b0;
      for (int i = 1; i < BYTE_LANES; i++) begin
         if (LINE_BYTE_MASK[i] && !starts[i] && (byte_mask[i] != byte_mask[i-1]))
            split = 1'b1;
      end
   end

   always_comb begin
      item.op         = op;
      item.idx        = IDX_MAX_W'(rem);
      item.elem_size  = elem_size;
      item.operand    = operand & LINE_BIT_MASK;
      item.mask_error = (op != EX_READ) && split;
      item.write_mask = ((op == EX_READ) || split) ? '0 : (byte_mask & LINE_BYTE_MASK);
   end

endmodule

FILE: rtl/asb_queue.sv
// ----------------------------------------------------------------------------
// asb_queue
// Short FIFO of classified words between the front and the back.
// ----------------------------------------------------------------------------
`include "atomic_scratchpad_bank_top_assert.svh"

module asb_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  asb_pkg::asb_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output asb_pkg::asb_item_type pop_item,
   output logic                  empty
);
   import asb_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   asb_item_type      slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = slot_ff[rd_ptr_ff];

   // pointer and fill tracking
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_item;
   end

   `ASB_ASSERT_IMPL(a_q_bound, clock, reset, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH), "queue overfilled")
   `ASB_ASSERT_IMPL(a_q_pop_nonempty, clock, reset, pop, !empty, "pop from empty queue")
   `ASB_ASSERT_NEXT(a_q_fill, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1, "fill count lost a word")

endmodule

FILE: rtl/asb_back.sv
// ----------------------------------------------------------------------------
// asb_back
// Owns the line memory: clears it after reset, then reads, combines and
// writes back one queued word at a time and holds the result for the port.
// ----------------------------------------------------------------------------
`include "atomic_scratchpad_bank_top_assert.svh"

module asb_back #(
   parameter int LINE_BYTES = 8,
   parameter int BANK_LINES = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_empty,
   input  asb_pkg::asb_item_type      q_item,
   output logic                       q_pop,
   output logic                       init_done,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [asb_pkg::DATA_W-1:0] rsp_result_data,
   output logic                       rsp_mask_error
);
   import asb_pkg::*;

   localparam int                IDX_W         = $clog2(BANK_LINES);
   localparam logic [IDX_W-1:0]  LAST_IDX      = IDX_W'(BANK_LINES - 1);
   localparam logic [DATA_W-1:0] LINE_BIT_MASK = line_bit_mask(LINE_BYTES);

   logic [DATA_W-1:0] mem [BANK_LINES];

   back_state_type    state_ff, state_in;
   logic [IDX_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic              init_done_ff, init_done_in;
   logic [5:0]        mul_cnt_ff, mul_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   asb_item_type      item_ff, item_in;
   logic [DATA_W-1:0] rd_data_ff;
   logic [DATA_W-1:0] old_ff, old_in;
   logic [DATA_W-1:0] res_ff, res_in;
   logic [DATA_W-1:0] a_sh_ff, a_sh_in;
   logic [DATA_W-1:0] b_sh_ff, b_sh_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_err_ff, rsp_err_in;

   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   logic [DATA_W-1:0]     mem_wdata;
   logic                  out_free;
   logic [BYTE_LANES-1:0] starts, tops;
   logic [DATA_W-1:0]     sum, diff, alu, start_bits, top_bits, addend, wbits, res_line;
   logic [BYTE_LANES-1:0] lt;
   logic [5:0]            mul_last;

   assign out_free        = !rsp_valid_ff || rsp_ready;
   assign init_done       = init_done_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_data = rsp_data_ff;
   assign rsp_mask_error  = rsp_err_ff;

   // element layout of the word in flight
   always_comb begin
      starts = lane_starts(item_ff.elem_size);
      tops   = {1'b1, starts[BYTE_LANES-1:1]};
      for (int i = 0; i < BYTE_LANES; i++) begin
         start_bits[8*i +: 8] = {7'd0, starts[i]};
         top_bits[8*i +: 8]   = {tops[i], 7'd0};
         wbits[8*i +: 8]      = {8{item_ff.write_mask[i]}};
      end
      unique case (item_ff.elem_size)
         ESZ_1:   mul_last = 6'd7;
         ESZ_2:   mul_last = 6'd15;
         ESZ_4:   mul_last = 6'd31;
         default: mul_last = 6'd63;
      endcase
   end

   // single-pass element ALU: add, subtract, signed max/min, write
   always_comb begin
      logic cur;
      cur  = 1'b0;
      sum  = seg_add(old_ff, item_ff.operand, 1'b0, starts);
      diff = seg_add(old_ff, ~item_ff.operand, 1'b1, starts);
      for (int j = BYTE_LANES - 1; j >= 0; j--) begin
         if (tops[j])
            cur = (old_ff[8*j+7] != item_ff.operand[8*j+7]) ? old_ff[8*j+7] : diff[8*j+7];
         lt[j] = cur;
      end
      alu = old_ff;
      case (item_ff.op)
         EX_ADD:   alu = sum;
         EX_SUB:   alu = diff;
         EX_WRITE: alu = item_ff.operand;
         EX_MAX: begin
            for (int j = 0; j < BYTE_LANES; j++)
               alu[8*j +: 8] = lt[j] ? item_ff.operand[8*j +: 8] : old_ff[8*j +: 8];
         end
         EX_MIN: begin
            for (int j = 0; j < BYTE_LANES; j++)
               alu[8*j +: 8] = lt[j] ? old_ff[8*j +: 8] : item_ff.operand[8*j +: 8];
         end
         default: alu = old_ff;
      endcase
   end

   // shift-and-add multiply step: one multiplier bit per element per cycle
   always_comb begin
      logic bit_sel;
      bit_sel = 1'b0;
      for (int i = 0; i < BYTE_LANES; i++) begin
         if (starts[i]) bit_sel = b_sh_ff[8*i];
         addend[8*i +: 8] = bit_sel ? a_sh_ff[8*i +: 8] : 8'd0;
      end
   end

   assign res_line = res_ff & LINE_BIT_MASK;

   // sequencer: next state and register inputs
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      init_done_in = init_done_ff;
      mul_cnt_in   = mul_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      item_in      = item_ff;
      old_in       = old_ff;
      res_in       = res_ff;
      a_sh_in      = a_sh_ff;
      b_sh_in      = b_sh_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = item_ff.idx[IDX_W-1:0];
      mem_wdata    = (old_ff & ~wbits) | (res_ff & wbits);

      // clearing pass after reset
      if (!init_done_ff) begin
         mem_we     = 1'b1;
         mem_waddr  = clr_cnt_ff;
         mem_wdata  = '0;
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == LAST_IDX) init_done_in = 1'b1;
      end

      unique case (state_ff)
         BS_IDLE: begin
            if (init_done_ff && !q_empty) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               state_in = BS_LOAD;
            end
         end
         BS_LOAD: begin
            old_in = rd_data_ff & LINE_BIT_MASK;
            if (item_ff.op == EX_MUL) begin
               res_in     = '0;
               a_sh_in    = rd_data_ff & LINE_BIT_MASK;
               b_sh_in    = item_ff.operand;
               mul_cnt_in = '0;
               state_in   = BS_MUL;
            end else begin
               state_in = BS_EXEC;
            end
         end
         BS_EXEC: begin
            res_in   = alu;
            state_in = BS_WRITE;
         end
         BS_MUL: begin
            res_in     = seg_add(res_ff, addend, 1'b0, starts);
            a_sh_in    = (a_sh_ff << 1) & ~start_bits;
            b_sh_in    = (b_sh_ff >> 1) & ~top_bits;
            mul_cnt_in = mul_cnt_ff + 1'b1;
            if (mul_cnt_ff == mul_last) state_in = BS_WRITE;
         end
         BS_WRITE: begin
            if (out_free) begin
               mem_we       = |item_ff.write_mask;
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_line;
               rsp_err_in   = item_ff.mask_error;
               state_in     = BS_IDLE;
            end
         end
         default: state_in = BS_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_IDLE;
         clr_cnt_ff   <= '0;
         init_done_ff <= 1'b0;
         mul_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         init_done_ff <= init_done_in;
         mul_cnt_ff   <= mul_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      old_ff      <= old_in;
      res_ff      <= res_in;
      a_sh_ff     <= a_sh_in;
      b_sh_ff     <= b_sh_in;
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
   end

   // line memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (q_pop) rd_data_ff <= mem[q_item.idx[IDX_W-1:0]];
   end

   `ASB_ASSERT_IMPL(a_wr_only_in_write, clock, reset, mem_we && init_done_ff, state_ff == BS_WRITE, "memory written outside write-back")
   `ASB_ASSERT_IMPL(a_no_wr_on_split, clock, reset, mem_we && init_done_ff, !item_ff.mask_error, "split mask reached memory")
   `ASB_ASSERT_NEXT(a_pop_loads, clock, reset, q_pop, state_ff == BS_LOAD, "popped word not loaded")
   `ASB_ASSERT_IMPL(a_mul_bound, clock, reset, state_ff == BS_MUL, mul_cnt_ff <= mul_last, "multiply ran past element width")

endmodule

FILE: rtl/atomic_scratchpad_bank_top.sv
// ----------------------------------------------------------------------------
// atomic_scratchpad_bank_top
// One scratchpad bank running atomic read-modify-write operations on lines.
//
//  channel | ports                         | dir | handshake
//  req     | req_type .. req_byte_mask     | in  | req_valid / req_ready
//  rsp     | rsp_result_data, mask_error   | out | rsp_valid / rsp_ready
//
// A word passes front -> 2-deep queue -> back. The back handles one word at a
// time: it loads, computes and writes back; mul computes one multiplier bit
// per element per cycle in the shared adder. After reset the back clears
// BANK_LINES lines, one per cycle; req_ready stays low until that pass ends.
// The result register frees the back while the previous word waits on
// rsp_ready; the queue keeps req_ready up meanwhile.
// ----------------------------------------------------------------------------
module atomic_scratchpad_bank_top #(
   parameter int LINE_BYTES = 8,
   parameter int BANK_LINES = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [2:0]                     req_type,
   input  logic [asb_pkg::ADDR_W-1:0]     req_line_addr,
   input  logic [1:0]                     req_elem_size,
   input  logic [asb_pkg::DATA_W-1:0]     req_operand,
   input  logic [asb_pkg::BYTE_LANES-1:0] req_byte_mask,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [asb_pkg::DATA_W-1:0]     rsp_result_data,
   output logic                           rsp_mask_error
);
   import asb_pkg::*;

   asb_item_type front_item;
   asb_item_type q_item;
   logic         q_full, q_empty, q_pop, init_done, push;

   assign req_ready = !q_full && init_done;
   assign push      = req_valid && req_ready;

   // classify
   asb_front #(
      .LINE_BYTES (LINE_BYTES),
      .BANK_LINES (BANK_LINES)
   ) u_front (
      .req_type  (req_type),
      .line_addr (req_line_addr),
      .elem_size (req_elem_size),
      .operand   (req_operand),
      .byte_mask (req_byte_mask),
      .item      (front_item)
   );

   // decouple
   asb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_item),
      .empty     (q_empty)
   );

   // execute
   asb_back #(
      .LINE_BYTES (LINE_BYTES),
      .BANK_LINES (BANK_LINES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .init_done       (init_done),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_data (rsp_result_data),
      .rsp_mask_error  (rsp_mask_error)
   );

endmodule

FILE: dv/asb_bank_checker.sv
// ----------------------------------------------------------------------------
// asb_bank_checker
// Watches both channels of the atomic scratchpad bank, keeps a shadow copy of
// the bank, predicts the reply to every accepted request word and compares it
// field by field with the reply words in order.
// ----------------------------------------------------------------------------
module asb_bank_checker #(
   parameter int LINE_BYTES = 8,
   parameter int BANK_LINES = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [2:0]                     req_type,
   input  logic [asb_pkg::ADDR_W-1:0]     req_line_addr,
   input  logic [1:0]                     req_elem_size,
   input  logic [asb_pkg::DATA_W-1:0]     req_operand,
   input  logic [asb_pkg::BYTE_LANES-1:0] req_byte_mask,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [asb_pkg::DATA_W-1:0]     rsp_result_data,
   input  logic                           rsp_mask_error,
   output int                             mismatch_count,
   output int                             words_outstanding
);
   import asb_pkg::*;

   // spare opcode, behaves like a read
   localparam logic [2:0] REQ_UNUSED = 3'd7;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic              mask_error;
   } bank_reply_type;

   logic [DATA_W-1:0] shadow_bank [BANK_LINES];
   bank_reply_type    awaited_replies [$];

   // one atomic access on the shadow bank: returns the reply, updates the line
   function automatic bank_reply_type atomic_outcome(input logic [2:0]            op,
                                                     input logic [ADDR_W-1:0]     addr,
                                                     input logic [1:0]            esz_code,
                                                     input logic [DATA_W-1:0]     operand,
                                                     input logic [BYTE_LANES-1:0] bmask);
      bank_reply_type    reply;
      int unsigned       idx;
      int unsigned       esz;
      int unsigned       ebits;
      logic [DATA_W-1:0] lmask, opnd, old, res, wmask, emask, sbit, a, b, r;
      logic              err;
      lmask = '0;
      for (int i = 0; i < BYTE_LANES; i++)
         if (i < LINE_BYTES) lmask[8*i +: 8] = 8'hFF;
      idx   = addr % BANK_LINES;
      esz   = 1 << esz_code;
      ebits = 8 * esz;
      opnd  = operand & lmask;
      old   = shadow_bank[idx] & lmask;
      res   = '0;
      wmask = '0;
      err   = 1'b0;

      if (op == REQ_READ || op == REQ_UNUSED) begin
         reply.data       = old;
         reply.mask_error = 1'b0;
         return reply;
      end

      emask = (ebits >= DATA_W) ? '1 : ((64'd1 << ebits) - 64'd1);
      sbit  = 64'd1 << (ebits - 1);
      for (int i = 0; i < LINE_BYTES && i < BYTE_LANES; i += esz) begin
         a = (old >> (8 * i)) & emask;
         b = (opnd >> (8 * i)) & emask;
         case (op)
            REQ_ADD: r = a + b;
            REQ_SUB: r = a - b;
            REQ_MUL: r = a * b;
            // signed compare by flipping the element's sign bit
            REQ_MAX: r = ((a ^ sbit) >= (b ^ sbit)) ? a : b;
            REQ_MIN: r = ((a ^ sbit) <= (b ^ sbit)) ? a : b;
            default: r = b;
         endcase
         res |= (r & emask) << (8 * i);
         // mask must agree on every byte of the element that is inside the line
         for (int j = 1; j < esz && i + j < LINE_BYTES && i + j < BYTE_LANES; j++)
            if (bmask[i+j] != bmask[i]) err = 1'b1;
      end
      res &= lmask;

      for (int i = 0; i < LINE_BYTES && i < BYTE_LANES; i++)
         if (bmask[i]) wmask[8*i +: 8] = 8'hFF;

      if (!err) shadow_bank[idx] = (old & ~wmask) | (res & wmask);

      reply.data       = res;
      reply.mask_error = err;
      return reply;
   endfunction

   // predict on each accepted request, compare on each accepted reply
   always @(posedge clock) begin
      int             fails;
      bank_reply_type want;
      fails = 0;
      if (reset) begin
         foreach (shadow_bank[k]) shadow_bank[k] = '0;
         awaited_replies.delete();
      end else begin
         if (req_valid && req_ready)
            awaited_replies.push_back(atomic_outcome(req_type, req_line_addr, req_elem_size,
                                                     req_operand, req_byte_mask));
         if (rsp_valid && rsp_ready) begin
            if (awaited_replies.size() == 0) begin
               $error("reply word with no request outstanding: result_data %h mask_error %b",
                      rsp_result_data, rsp_mask_error);
               fails++;
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_result_data !== want.data) begin
                  $error("result_data: expected %h, actual %h", want.data, rsp_result_data);
                  fails++;
               end
               if (rsp_mask_error !== want.mask_error) begin
                  $error("mask_error: expected %b, actual %b", want.mask_error,
                         rsp_mask_error);
                  fails++;
               end
            end
         end
      end
      mismatch_count    <= mismatch_count + fails;
      words_outstanding <= awaited_replies.size();
   end

endmodule

FILE: dv/tb_atomic_scratchpad_bank_top.sv
// ----------------------------------------------------------------------------
// tb_atomic_scratchpad_bank_top
// Drives request words into the atomic scratchpad bank: a directed opening on
// every operation, element size, mask corner and value extreme, then random
// words biased toward a few hot lines so same-line hazards occur back to back.
// The reply side stalls on its own pattern, with long hold-offs that back the
// bank up. The checker beside the block scores every reply word.
// ----------------------------------------------------------------------------
module tb_atomic_scratchpad_bank_top;
   import asb_pkg::*;

   localparam int LINE_BYTES     = 8;
   localparam int BANK_LINES     = 1024;
   localparam int CLK_PERIOD     = 10;
   localparam int RANDOM_WORDS   = 1600;
   localparam int LONG_HOLD      = 300;
   localparam int DRAIN_LIMIT    = 20000;
   localparam int SETTLE_CYCLES  = 120;
   localparam int TIMEOUT_CYCLES = 1000000;

   // top line of the bank and a hot line for hazard runs
   localparam logic [ADDR_W-1:0] LAST_LINE = ADDR_W'(BANK_LINES - 1);
   localparam logic [ADDR_W-1:0] HOT_LINE  = ADDR_W'(2);

   typedef enum int {
      FILL_ZERO,
      FILL_ONES,
      FILL_MIN,
      FILL_MAX,
      FILL_ONE
   } fill_kind_type;

   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_ready;
   logic [2:0]            req_type      = REQ_READ;
   logic [ADDR_W-1:0]     req_line_addr = '0;
   logic [1:0]            req_elem_size = ESZ_1;
   logic [DATA_W-1:0]     req_operand   = '0;
   logic [BYTE_LANES-1:0] req_byte_mask = '0;
   logic                  rsp_valid;
   logic                  rsp_ready     = 1'b0;
   logic [DATA_W-1:0]     rsp_result_data;
   logic                  rsp_mask_error;
   int                    mismatch_count;
   int                    words_outstanding;

   atomic_scratchpad_bank_top #(
      .LINE_BYTES(LINE_BYTES),
      .BANK_LINES(BANK_LINES)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_line_addr  (req_line_addr),
      .req_elem_size  (req_elem_size),
      .req_operand    (req_operand),
      .req_byte_mask  (req_byte_mask),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_result_data(rsp_result_data),
      .rsp_mask_error (rsp_mask_error)
   );

   asb_bank_checker #(
      .LINE_BYTES(LINE_BYTES),
      .BANK_LINES(BANK_LINES)
   ) bank_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_line_addr    (req_line_addr),
      .req_elem_size    (req_elem_size),
      .req_operand      (req_operand),
      .req_byte_mask    (req_byte_mask),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_data  (rsp_result_data),
      .rsp_mask_error   (rsp_mask_error),
      .mismatch_count   (mismatch_count),
      .words_outstanding(words_outstanding)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // line with the same value in every element: zero, -1, most negative,
   // most positive or one
   function automatic logic [DATA_W-1:0] lane_fill(input logic [1:0]    esz_code,
                                                   input fill_kind_type kind);
      logic [DATA_W-1:0] v;
      int unsigned       nbytes;
      int unsigned       pos;
      v      = '0;
      nbytes = 1 << esz_code;
      for (int b = 0; b < BYTE_LANES; b++) begin
         pos = b % nbytes;
         case (kind)
            FILL_ONES: v[8*b +: 8] = 8'hFF;
            FILL_MIN:  v[8*b +: 8] = (pos == nbytes - 1) ? 8'h80 : 8'h00;
            FILL_MAX:  v[8*b +: 8] = (pos == nbytes - 1) ? 8'h7F : 8'hFF;
            FILL_ONE:  v[8*b +: 8] = (pos == 0) ? 8'h01 : 8'h00;
            default:   v[8*b +: 8] = 8'h00;
         endcase
      end
      return v;
   endfunction

   // offer one word and hold it until the bank takes it; valid stays high
   task automatic send_word(input logic [2:0]            op,
                            input logic [ADDR_W-1:0]     addr,
                            input logic [1:0]            esz,
                            input logic [DATA_W-1:0]     opnd,
                            input logic [BYTE_LANES-1:0] bmask);
      req_valid     <= 1'b1;
      req_type      <= op;
      req_line_addr <= addr;
      req_elem_size <= esz;
      req_operand   <= opnd;
      req_byte_mask <= bmask;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid for a number of cycles
   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // reply side: changing stall modes, plus long hold-offs at set reply counts
   int unsigned rx_taken     = 0;
   int unsigned rx_hold      = 0;
   int unsigned rx_mode      = 0;
   int unsigned rx_mode_left = 0;
   int unsigned rx_cycle     = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rx_cycle++;
         if (rsp_valid && rsp_ready) begin
            rx_taken++;
            if (rx_taken % 700 == 200) rx_hold = LONG_HOLD;
         end
         if (rx_hold != 0) begin
            rx_hold--;
            rsp_ready <= 1'b0;
         end else begin
            if (rx_mode_left == 0) begin
               rx_mode      = $urandom_range(0, 3);
               rx_mode_left = $urandom_range(16, 160);
            end else begin
               rx_mode_left--;
            end
            case (rx_mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               2:       rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= (rx_cycle % 7 < 4);
            endcase
         end
      end
   end

   // stimulus and verdict
   initial begin
      int                    burst;
      int                    roll;
      int                    waited;
      logic [2:0]            op;
      logic [1:0]            esz;
      logic [ADDR_W-1:0]     addr;
      logic [DATA_W-1:0]     opnd;
      logic [BYTE_LANES-1:0] bmask;
      logic [31:0]           lane_bits;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: value extremes, wrap-around, split and empty masks
      send_word(REQ_READ, '0, ESZ_1, '1, 8'hA5);
      send_word(REQ_WRITE, LAST_LINE, ESZ_8, lane_fill(ESZ_8, FILL_MIN), 8'hFF);
      send_word(REQ_MAX, LAST_LINE, ESZ_8, lane_fill(ESZ_8, FILL_MAX), 8'hFF);
      send_word(REQ_MIN, LAST_LINE, ESZ_4, lane_fill(ESZ_4, FILL_MIN), 8'hFF);
      send_word(REQ_ADD, LAST_LINE, ESZ_1, lane_fill(ESZ_1, FILL_ONES), 8'hFF);
      send_word(REQ_SUB, LAST_LINE, ESZ_2, lane_fill(ESZ_2, FILL_MIN), 8'hFF);
      send_word(REQ_MUL, LAST_LINE, ESZ_8, lane_fill(ESZ_8, FILL_ONES), 8'hFF);
      send_word(REQ_MUL, LAST_LINE, ESZ_1, lane_fill(ESZ_1, FILL_MIN), 8'hFF);
      send_word(REQ_ADD, LAST_LINE, ESZ_2, '1, 8'h01);
      send_word(REQ_WRITE, LAST_LINE, ESZ_4, '0, 8'h0F);
      send_word(REQ_WRITE, LAST_LINE, ESZ_4, '1, 8'h00);
      send_word(REQ_READ, LAST_LINE, ESZ_8, '0, 8'h3C);
      // every opcode, the spare one included
      for (int k = 0; k < 8; k++)
         send_word(3'(k), HOT_LINE, 2'(k), {$urandom, $urandom}, 8'hFF);
      // same-line read-modify-write back to back
      send_word(REQ_ADD, HOT_LINE, ESZ_8, lane_fill(ESZ_8, FILL_ONE), 8'hFF);
      send_word(REQ_ADD, HOT_LINE, ESZ_8, lane_fill(ESZ_8, FILL_ONE), 8'hFF);
      send_word(REQ_READ, HOT_LINE, ESZ_8, '0, 8'h00);

      // random words in bursts
      for (int n = 0; n < RANDOM_WORDS; ) begin
         burst = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                              : $urandom_range(1, 12);
         for (int k = 0; k < burst && n < RANDOM_WORDS; k++, n++) begin
            roll = $urandom_range(0, 99);
            op   = (roll < 30) ? 3'($urandom_range(0, 7))
                               : 3'($urandom_range(REQ_ADD, REQ_WRITE));
            esz  = 2'($urandom_range(0, 3));

            // hot lines dominate so hazards hit in flight
            roll = $urandom_range(0, 99);
            if (roll < 40)      addr = ADDR_W'($urandom_range(0, 3));
            else if (roll < 55) addr = ADDR_W'($urandom_range(BANK_LINES - 4, BANK_LINES - 1));
            else                addr = ADDR_W'($urandom_range(0, BANK_LINES - 1));

            roll = $urandom_range(0, 99);
            opnd = (roll < 60) ? {$urandom, $urandom}
                               : lane_fill(esz, fill_kind_type'($urandom_range(0, 4)));

            // mostly element-uniform masks so writes land
            roll = $urandom_range(0, 99);
            if (roll < 20) begin
               bmask = 8'hFF;
            end else if (roll < 40) begin
               bmask = 8'($urandom_range(0, 255));
            end else begin
               lane_bits = $urandom;
               for (int b = 0; b < BYTE_LANES; b++) bmask[b] = lane_bits[b >> esz];
            end

            send_word(op, addr, esz, opnd, bmask);
         end
         if (n < RANDOM_WORDS)
            pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
      end
      req_valid <= 1'b0;

      // drain, then let a slow multiply finish
      waited = 0;
      while (words_outstanding != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && words_outstanding == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // hang guard
   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("Mismatches found");
      $finish;
   end

endmodule
